>>> hw/rtl/itcf_pkg.sv
`default_nettype none
package itcf_pkg;

    // CORDIC datapath width, trig result width, multiplier operand widths
    localparam int CW        = 36;
    localparam int TW        = 33;
    localparam int MA_W      = 48;
    localparam int MB_W      = 33;
    localparam int PW        = 64;
    localparam int PRED_W    = 42;
    localparam int NUM_W     = 48;
    localparam int DIV_STEPS = 48;

    localparam logic signed [63:0] PI_Q30       = 64'sd3373259426;
    localparam logic signed [63:0] HALF_PI_Q30  = 64'sd1686629713;
    localparam logic signed [63:0] TWO_PI_Q30   = 64'sd6746518852;
    localparam logic signed [63:0] GAIN_INV_Q30 = 64'sd652032874;
    localparam logic signed [63:0] TAN_LIMIT    = 64'sd2147483647;
    localparam logic signed [63:0] PRED_LIMIT   = 64'sd1099511627776;
    localparam logic signed [63:0] ANGLE_MAX    = 64'sd524287;
    localparam logic signed [63:0] ANGLE_MIN    = -64'sd524288;
    localparam int                 ONE_G        = 16384;

    localparam logic REG_BLEND = 1'b0;
    localparam logic REG_SCALE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SQRT, S_CGO, S_CWAIT, S_RED,
        S_DIVGO, S_DIV, S_TAN, S_UPD, S_FIN
    } state_t;

    typedef enum logic [3:0] {
        OP_AXSQ, OP_SRT, OP_TGY, OP_CRT, OP_TGZ, OP_CGY, OP_SGZ,
        OP_SCX, OP_SCY, OP_WPX, OP_WAX, OP_WPY, OP_WAY
    } mul_op_t;

    typedef enum logic [1:0] {J_RACC, J_PACC, J_SINR, J_SINP} job_t;

    typedef struct packed {
        logic start;
        logic vec_mode;
    } cordic_ctl_t;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/imu_tilt_complementary_filter.sv
`default_nettype none
// Roll/pitch complementary filter for one raw six-axis IMU sample per item.
// Input channel: in_valid/in_stall carries accel_x/y/z and gyro_x/y/z; an item
// is taken at a clock edge with in_valid high and in_stall low. in_stall is
// high whenever a sample is being worked on.
// Output channel: out_valid/out_stall carries roll_angle and pitch_angle in
// Q(19-ANGLE_FRAC_BITS).ANGLE_FRAC_BITS radians; the result sits in an output
// register, so the next sample is taken while the previous result still waits.
// Each item runs through one sequencer: a 15-step square root, four CORDIC
// passes (three when accel_z is zero: no pitch pass), a 48-step divider
// (skipped when the pitch cosine is zero), thirteen multiplies on one split
// multiplier and the range reduction of both angles (at most one 2*pi wrap
// at the defaults, more for small ANGLE_FRAC_BITS). A new item is taken only
// once the previous one has finished and its result has been placed.
// Configuration: cfg_write with cfg_index 0 (blend weight) or 1 (gyro step
// scale); write only while idle.
// Reset clears both angle estimates, loads the default configuration and
// drops out_valid. A stalled result holds until taken; a finished item whose
// result cannot be placed waits, with in_stall high.
module imu_tilt_complementary_filter #(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int CORDIC_STEPS    = 20
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic               cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] accel_x,
    input  wire logic signed [15:0] accel_y,
    input  wire logic signed [15:0] accel_z,
    input  wire logic signed [15:0] gyro_x,
    input  wire logic signed [15:0] gyro_y,
    input  wire logic signed [15:0] gyro_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [19:0]      roll_angle,
    output logic signed [19:0]      pitch_angle
);
    import itcf_pkg::*;

    localparam int SH = 30 - ANGLE_FRAC_BITS;
    localparam int AW = (52 - ANGLE_FRAC_BITS > CW) ? 52 - ANGLE_FRAC_BITS : CW;

    localparam logic signed [AW-1:0] PI_A      = AW'(PI_Q30);
    localparam logic signed [AW-1:0] HALF_PI_A = AW'(HALF_PI_Q30);
    localparam logic signed [AW-1:0] TWO_PI_A  = AW'(TWO_PI_Q30);
    localparam logic signed [47:0]   RND       = 48'sd1 <<< (SH - 1);

    state_t  state_reg, state_next;
    mul_op_t op_reg;
    job_t    job_reg;
    logic [1:0] mph_reg;
    logic [5:0] div_cnt_reg;
    logic [15:0] weight_reg, scale_reg;
    logic signed [19:0] roll_est_reg, pitch_est_reg;
    logic out_valid_reg;
    logic signed [19:0] roll_out_reg, pitch_out_reg;

    logic signed [15:0] axc_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;
    logic [29:0] n_reg, r_reg, bit_reg;
    logic signed [AW-1:0] ang_reg;
    logic neg_reg;
    logic signed [CW-1:0] racc_reg, pacc_reg;
    logic signed [TW-1:0] sr_reg, cr_reg, sp_reg, cp_reg;
    logic [TW:0]          rem_reg;
    logic [NUM_W-1:0]     quo_reg;
    logic [TW-1:0]        den_reg;
    logic                 div_neg_reg;
    logic signed [31:0]   tq_reg;
    logic signed [57:0]   plo_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [47:0]   tmp_reg;
    logic signed [PW-1:0] rx_reg, ry_reg, mix_reg, mixx_reg, mixy_reg;
    logic signed [PRED_W-1:0] predx_reg, predy_reg;

    cordic_ctl_t          cctl;
    logic signed [CW-1:0] c_x_in, c_y_in, c_z_in, c_x, c_y, c_z;
    logic                 c_done;

    logic accept, fin_load, mul_last, red_hi, red_lo;
    logic signed [15:0]   axc_in;
    logic signed [16:0]   pax, pay;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [57:0]   plo;
    logic signed [56:0]   phi;
    logic [29:0]          sq_try;
    logic [TW:0]          rem_sh;
    logic [TW-1:0]        abs_sp, abs_cp;
    logic [16:0]          wt_c;
    logic signed [TW-1:0] trig_s, trig_c;
    logic signed [19:0]   qx, qy;

    function automatic logic signed [PRED_W-1:0] clamp_pred(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] r;
        if (v > PRED_LIMIT)
            r = PRED_LIMIT;
        else if (v < -PRED_LIMIT)
            r = -PRED_LIMIT;
        else
            r = v;
        return PRED_W'(r);
    endfunction

    function automatic logic signed [19:0] quant(input logic signed [PW-1:0] mix);
        logic signed [47:0] s;
        logic signed [47:0] q;
        logic signed [19:0] r;
        s = $signed(mix[63:16]) + RND;
        q = s >>> SH;
        if (q > 48'(ANGLE_MAX))
            r = 20'(ANGLE_MAX);
        else if (q < 48'(ANGLE_MIN))
            r = 20'(ANGLE_MIN);
        else
            r = 20'(q);
        return r;
    endfunction

    itcf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cctl),
        .x_in  (c_x_in),
        .y_in  (c_y_in),
        .z_in  (c_z_in),
        .done  (c_done),
        .x_out (c_x),
        .y_out (c_y),
        .z_out (c_z)
    );

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign fin_load = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);
    assign mul_last = (mph_reg == 2'd2);
    assign red_hi   = ang_reg > PI_A;
    assign red_lo   = ang_reg <= -PI_A;

    always_comb
    begin
        if (accel_x > 16'sd16384)
            axc_in = 16'sd16384;
        else if (accel_x < -16'sd16384)
            axc_in = -16'sd16384;
        else
            axc_in = accel_x;
        pax    = (az_reg > 0) ? 17'(az_reg) : -17'(az_reg);
        pay    = (az_reg > 0) ? 17'(ay_reg) : -17'(ay_reg);
        sq_try = r_reg + bit_reg;
        rem_sh = {rem_reg[TW-1:0], quo_reg[NUM_W-1]};
        abs_sp = (sp_reg < 0) ? TW'(-sp_reg) : TW'(sp_reg);
        abs_cp = (cp_reg < 0) ? TW'(-cp_reg) : TW'(cp_reg);
        wt_c   = 17'(17'd65536 - {1'b0, weight_reg});
        trig_s = neg_reg ? TW'(-c_y) : TW'(c_y);
        trig_c = neg_reg ? TW'(-c_x) : TW'(c_x);
        qx     = quant(mixx_reg);
        qy     = quant(mixy_reg);
    end

    // multiplier operand select
    always_comb
    begin
        case (op_reg)
            OP_AXSQ: begin mul_a = MA_W'(axc_reg);   mul_b = MB_W'(axc_reg); end
            OP_SRT:  begin mul_a = MA_W'(sr_reg);    mul_b = MB_W'(tq_reg);  end
            OP_TGY:  begin mul_a = tmp_reg;          mul_b = MB_W'(gy_reg);  end
            OP_CRT:  begin mul_a = MA_W'(cr_reg);    mul_b = MB_W'(tq_reg);  end
            OP_TGZ:  begin mul_a = tmp_reg;          mul_b = MB_W'(gz_reg);  end
            OP_CGY:  begin mul_a = MA_W'(cr_reg);    mul_b = MB_W'(gy_reg);  end
            OP_SGZ:  begin mul_a = MA_W'(sr_reg);    mul_b = MB_W'(gz_reg);  end
            OP_SCX:  begin mul_a = $signed(rx_reg[63:16]); mul_b = $signed({17'b0, scale_reg}); end
            OP_SCY:  begin mul_a = $signed(ry_reg[63:16]); mul_b = $signed({17'b0, scale_reg}); end
            OP_WPX:  begin mul_a = MA_W'(predx_reg); mul_b = $signed({16'b0, wt_c}); end
            OP_WAX:  begin mul_a = MA_W'(racc_reg);  mul_b = $signed({17'b0, weight_reg}); end
            OP_WPY:  begin mul_a = MA_W'(predy_reg); mul_b = $signed({16'b0, wt_c}); end
            OP_WAY:  begin mul_a = MA_W'(pacc_reg);  mul_b = $signed({17'b0, weight_reg}); end
            default: begin mul_a = '0;               mul_b = '0; end
        endcase
        plo = $signed({1'b0, mul_a[23:0]}) * mul_b;
        phi = $signed(mul_a[47:24]) * mul_b;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_MUL;
            S_MUL:
            begin
                if (mul_last && op_reg == OP_AXSQ)
                    state_next = S_SQRT;
                else if (mul_last && op_reg == OP_WAY)
                    state_next = S_UPD;
            end
            S_SQRT:  if (bit_reg[0]) state_next = S_CGO;
            S_CGO:   state_next = S_CWAIT;
            S_CWAIT:
            begin
                if (c_done)
                begin
                    case (job_reg)
                        J_RACC:  state_next = (az_reg == 0) ? S_RED : S_CGO;
                        J_PACC:  state_next = S_RED;
                        J_SINR:  state_next = S_RED;
                        default: state_next = S_DIVGO;
                    endcase
                end
            end
            S_RED:   if (!red_hi && !red_lo) state_next = S_CGO;
            S_DIVGO: state_next = (cp_reg == 0) ? S_MUL : S_DIV;
            S_DIV:   if (div_cnt_reg == 6'(DIV_STEPS - 1)) state_next = S_TAN;
            S_TAN:   state_next = S_MUL;
            S_UPD:   state_next = S_FIN;
            S_FIN:   if (fin_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        cctl.start    = (state_reg == S_CGO);
        cctl.vec_mode = (job_reg == J_RACC) || (job_reg == J_PACC);
        case (job_reg)
            J_RACC:
            begin
                c_x_in = CW'($signed({1'b0, r_reg})) <<< 16;
                c_y_in = CW'(axc_reg) <<< 16;
                c_z_in = '0;
            end
            J_PACC:
            begin
                c_x_in = CW'(pax) <<< 16;
                c_y_in = CW'(pay) <<< 16;
                c_z_in = '0;
            end
            default:
            begin
                c_x_in = CW'(GAIN_INV_Q30);
                c_y_in = '0;
                c_z_in = CW'(ang_reg);
            end
        endcase
        in_stall = (state_reg != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_AXSQ;
            job_reg       <= J_RACC;
            mph_reg       <= '0;
            div_cnt_reg   <= '0;
            weight_reg    <= 16'd1311;
            scale_reg     <= 16'd2750;
            roll_est_reg  <= '0;
            pitch_est_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_BLEND: weight_reg <= cfg_data;
                    REG_SCALE: scale_reg  <= cfg_data;
                    default: ;
                endcase
            end
            mph_reg <= (state_reg == S_MUL && !mul_last) ? mph_reg + 2'd1 : 2'd0;
            case (state_reg)
                S_IDLE:  if (in_valid) op_reg <= OP_AXSQ;
                S_MUL:
                begin
                    if (mul_last && op_reg != OP_AXSQ && op_reg != OP_WAY)
                        op_reg <= mul_op_t'(op_reg + 4'd1);
                end
                S_SQRT:  job_reg <= J_RACC;
                S_CWAIT:
                begin
                    if (c_done)
                    begin
                        case (job_reg)
                            J_RACC:  job_reg <= (az_reg == 0) ? J_SINR : J_PACC;
                            J_PACC:  job_reg <= J_SINR;
                            J_SINR:  job_reg <= J_SINP;
                            default: job_reg <= J_SINP;
                        endcase
                    end
                end
                S_DIVGO:
                begin
                    div_cnt_reg <= '0;
                    op_reg      <= OP_SRT;
                end
                S_DIV:   div_cnt_reg <= div_cnt_reg + 6'd1;
                S_TAN:   op_reg <= OP_SRT;
                S_UPD:
                begin
                    roll_est_reg  <= qx;
                    pitch_est_reg <= qy;
                end
                default: ;
            endcase
            if (fin_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    axc_reg <= axc_in;
                    ay_reg  <= accel_y;
                    az_reg  <= accel_z;
                    gx_reg  <= gyro_x;
                    gy_reg  <= gyro_y;
                    gz_reg  <= gyro_z;
                end
            end
            S_MUL:
            begin
                case (mph_reg)
                    2'd0: plo_reg  <= plo;
                    2'd1: prod_reg <= (PW'(phi) <<< 24) + PW'(plo_reg);
                    default:
                    begin
                        case (op_reg)
                            OP_AXSQ:
                            begin
                                n_reg   <= 30'(ONE_G * ONE_G) - prod_reg[29:0];
                                r_reg   <= '0;
                                bit_reg <= 30'd1 << 28;
                            end
                            OP_SRT: tmp_reg <= $signed(prod_reg[63:16]);
                            OP_TGY: rx_reg  <= (PW'(gx_reg) <<< 30) + prod_reg;
                            OP_CRT: tmp_reg <= $signed(prod_reg[63:16]);
                            OP_TGZ: rx_reg  <= rx_reg + prod_reg;
                            OP_CGY: ry_reg  <= prod_reg;
                            OP_SGZ: ry_reg  <= ry_reg - prod_reg;
                            OP_SCX: predx_reg <= clamp_pred((PW'(roll_est_reg) <<< SH)
                                                 + PW'($signed(prod_reg[63:16])));
                            OP_SCY: predy_reg <= clamp_pred((PW'(pitch_est_reg) <<< SH)
                                                 + PW'($signed(prod_reg[63:16])));
                            OP_WPX: mix_reg  <= prod_reg;
                            OP_WAX: mixx_reg <= mix_reg + prod_reg + 64'sd32768;
                            OP_WPY: mix_reg  <= prod_reg;
                            OP_WAY: mixy_reg <= mix_reg + prod_reg + 64'sd32768;
                            default: ;
                        endcase
                    end
                endcase
            end
            S_SQRT:
            begin
                if (n_reg >= sq_try)
                begin
                    n_reg <= n_reg - sq_try;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                    r_reg <= r_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            S_CWAIT:
            begin
                if (c_done)
                begin
                    case (job_reg)
                        J_RACC:
                        begin
                            racc_reg <= c_z;
                            if (az_reg == 0)
                            begin
                                // flat on its side: right angle by the sign of Y, zero when Y is zero
                                if (ay_reg > 0)
                                    pacc_reg <= CW'(HALF_PI_Q30);
                                else if (ay_reg < 0)
                                    pacc_reg <= -CW'(HALF_PI_Q30);
                                else
                                    pacc_reg <= '0;
                                ang_reg <= AW'(roll_est_reg) <<< SH;
                            end
                        end
                        J_PACC:
                        begin
                            pacc_reg <= c_z;
                            ang_reg  <= AW'(roll_est_reg) <<< SH;
                        end
                        J_SINR:
                        begin
                            sr_reg  <= trig_s;
                            cr_reg  <= trig_c;
                            ang_reg <= AW'(pitch_est_reg) <<< SH;
                        end
                        default:
                        begin
                            sp_reg <= trig_s;
                            cp_reg <= trig_c;
                        end
                    endcase
                end
            end
            S_RED:
            begin
                // wrap into (-pi, pi], then fold into [-pi/2, pi/2]
                if (red_hi)
                    ang_reg <= ang_reg - TWO_PI_A;
                else if (red_lo)
                    ang_reg <= ang_reg + TWO_PI_A;
                else if (ang_reg > HALF_PI_A)
                begin
                    ang_reg <= ang_reg - PI_A;
                    neg_reg <= 1'b1;
                end
                else if (ang_reg < -HALF_PI_A)
                begin
                    ang_reg <= ang_reg + PI_A;
                    neg_reg <= 1'b1;
                end
                else
                    neg_reg <= 1'b0;
            end
            S_DIVGO:
            begin
                if (cp_reg == 0)
                    tq_reg <= (sp_reg >= 0) ? 32'(TAN_LIMIT) : -32'(TAN_LIMIT);
                rem_reg     <= '0;
                quo_reg     <= {abs_sp[31:0], 16'b0};
                den_reg     <= abs_cp;
                div_neg_reg <= (sp_reg < 0) ^ (cp_reg < 0);
            end
            S_DIV:
            begin
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, den_reg};
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
                end
            end
            S_TAN:
            begin
                if (quo_reg > NUM_W'(TAN_LIMIT))
                    tq_reg <= div_neg_reg ? -32'(TAN_LIMIT) : 32'(TAN_LIMIT);
                else
                    tq_reg <= div_neg_reg ? -$signed({1'b0, quo_reg[30:0]})
                                          : $signed({1'b0, quo_reg[30:0]});
            end
            default: ;
        endcase
        if (fin_load)
        begin
            roll_out_reg  <= roll_est_reg;
            pitch_out_reg <= pitch_est_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign roll_angle  = roll_out_reg;
    assign pitch_angle = pitch_out_reg;

endmodule
`default_nettype wire

>>> hw/rtl/itcf_cordic.sv
`default_nettype none
module itcf_cordic #(
    parameter int STEPS = 20
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire itcf_pkg::cordic_ctl_t           ctl,
    input  wire logic signed [itcf_pkg::CW-1:0]  x_in,
    input  wire logic signed [itcf_pkg::CW-1:0]  y_in,
    input  wire logic signed [itcf_pkg::CW-1:0]  z_in,
    output logic                                 done,
    output logic signed [itcf_pkg::CW-1:0]       x_out,
    output logic signed [itcf_pkg::CW-1:0]       y_out,
    output logic signed [itcf_pkg::CW-1:0]       z_out
);
    import itcf_pkg::*;

    localparam int CNT_W = $clog2(STEPS + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 vec_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic [4:0]           idx;
    logic signed [CW-1:0] xs, ys, a;
    logic                 sigma;

    always_comb
    begin
        idx   = 5'(cnt_reg);
        xs    = x_reg >>> idx;
        ys    = y_reg >>> idx;
        a     = CW'($signed({1'b0, atan_q30(idx)}));
        // rotation drives z to zero, vectoring drives y to zero
        sigma = vec_reg ? !(y_reg > 0) : (z_reg >= 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start && !busy_reg)
        begin
            vec_reg <= ctl.vec_mode;
            x_reg   <= x_in;
            y_reg   <= y_in;
            z_reg   <= z_in;
        end
        else if (busy_reg)
        begin
            if (sigma)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - a;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + a;
            end
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule
`default_nettype wire

>>> test/imu_tilt_complementary_filter_test.sv
`default_nettype none
module imu_tilt_complementary_filter_test;
    import itcf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FRAC       = 16;
    localparam int  STEPS      = 20;
    localparam int  HOLD_LEN   = 3000;
    localparam int  SETTLE     = 400;
    localparam int  WATCH_MAX  = 20000;
    localparam int  RAND_ITEMS = 112;

    localparam longint ARCTAN [0:19] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048
    };

    typedef struct packed {
        logic signed [19:0] roll;
        logic signed [19:0] pitch;
    } tilt_t;

    typedef struct {
        bit                 set_cfg;
        int                 weight;
        int                 scale;
        logic signed [15:0] ax, ay, az, gx, gy, gz;
        bit                 known;
        tilt_t              tilt;
    } sample_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_write;
    logic                cfg_index;
    logic [15:0]         cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic signed [15:0]  accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z;
    logic                out_valid;
    logic                out_stall;
    logic signed [19:0]  roll_angle, pitch_angle;

    imu_tilt_complementary_filter dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle)
    );

    // filter state and registers as the block should hold them
    longint roll_est, pitch_est;
    longint weight_q, scale_q;
    tilt_t  pending_tilts[$];
    int     failures;
    int     idle_cycles;
    int     send_idle_pct, recv_stall_pct;
    int     hold_asked, hold_served, hold_left;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void rotate_sincos(input longint ang, output longint s,
                                          output longint c);
        longint x, y, z, nx;
        bit     flip;
        x = 652032874;
        y = 0;
        flip = 0;
        while (ang > PI_Q30) ang -= TWO_PI_Q30;
        while (ang <= -PI_Q30) ang += TWO_PI_Q30;
        if (ang > HALF_PI_Q30)
        begin
            ang -= PI_Q30;
            flip = 1;
        end
        else if (ang < -HALF_PI_Q30)
        begin
            ang += PI_Q30;
            flip = 1;
        end
        z = ang;
        for (int i = 0; i < STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= ARCTAN[i];
            end
            else
            begin
                nx = x + (y >>> i); y = y - (x >>> i); z += ARCTAN[i];
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint vector_angle(input longint xin, input longint yin);
        longint x, y, z, nx;
        x = xin * 65536;
        y = yin * 65536;
        z = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i); y = y - (x >>> i); z += ARCTAN[i];
            end
            else
            begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= ARCTAN[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint root_floor(input longint n);
        longint r, b;
        r = 0;
        b = longint'(1) << 30;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint fuse_angle(input longint old, input longint step,
                                          input longint acc);
        longint pred, mix, q;
        pred = old * (longint'(1) << (30 - FRAC)) + step;
        if (pred > PRED_LIMIT) pred = PRED_LIMIT;
        if (pred < -PRED_LIMIT) pred = -PRED_LIMIT;
        mix = ((65536 - weight_q) * pred + weight_q * acc + 32768) >>> 16;
        q = (mix + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
        if (q > ANGLE_MAX) q = ANGLE_MAX;
        if (q < ANGLE_MIN) q = ANGLE_MIN;
        return q;
    endfunction

    function automatic tilt_t advance_tilt(input longint ax, input longint ay,
                                           input longint az, input longint gx,
                                           input longint gy, input longint gz);
        longint axc, racc, pacc, sr, cr, sp, cp, tq, rx, ry;
        tilt_t  t;
        axc = ax > ONE_G ? ONE_G : (ax < -ONE_G ? -ONE_G : ax);
        racc = vector_angle(root_floor(ONE_G * ONE_G - axc * axc), axc);
        if (az == 0)
            pacc = ay > 0 ? HALF_PI_Q30 : (ay < 0 ? -HALF_PI_Q30 : 0);
        else if (az > 0)
            pacc = vector_angle(az, ay);
        else
            pacc = vector_angle(-az, -ay);
        rotate_sincos(roll_est * (longint'(1) << (30 - FRAC)), sr, cr);
        rotate_sincos(pitch_est * (longint'(1) << (30 - FRAC)), sp, cp);
        if (cp == 0)
            tq = sp >= 0 ? TAN_LIMIT : -TAN_LIMIT;
        else
        begin
            tq = (sp * 65536) / cp;
            if (tq > TAN_LIMIT) tq = TAN_LIMIT;
            if (tq < -TAN_LIMIT) tq = -TAN_LIMIT;
        end
        rx = gx * (longint'(1) << 30) + ((sr * tq) >>> 16) * gy
             + ((cr * tq) >>> 16) * gz;
        ry = cr * gy - sr * gz;
        roll_est = fuse_angle(roll_est, ((rx >>> 16) * scale_q) >>> 16, racc);
        pitch_est = fuse_angle(pitch_est, ((ry >>> 16) * scale_q) >>> 16, pacc);
        t.roll = roll_est[19:0];
        t.pitch = pitch_est[19:0];
        return t;
    endfunction

    // predict on input handshakes, check on output handshakes
    always @(posedge clk)
    begin
        tilt_t want;
        bit    moved;
        if (rst_n)
        begin
            moved = (in_valid && !in_stall) || (out_valid && !out_stall);
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (in_valid && !in_stall)
            begin
                pending_tilts.push_back(advance_tilt(accel_x, accel_y, accel_z,
                                                     gyro_x, gyro_y, gyro_z));
            end
            if (out_valid && !out_stall)
            begin
                if (pending_tilts.size() == 0)
                begin
                    $error("result with no item pending: roll %0d pitch %0d",
                           roll_angle, pitch_angle);
                    failures++;
                end
                else
                begin
                    want = pending_tilts.pop_front();
                    if (roll_angle !== want.roll)
                    begin
                        $error("roll_angle expected %0d actual %0d", want.roll, roll_angle);
                        failures++;
                    end
                    if (pitch_angle !== want.pitch)
                    begin
                        $error("pitch_angle expected %0d actual %0d",
                               want.pitch, pitch_angle);
                        failures++;
                    end
                end
            end
            if (idle_cycles >= WATCH_MAX)
            begin
                $display("imu_tilt_complementary_filter_test NOT OK");
                $finish;
            end
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (hold_asked != hold_served)
            begin
                hold_served = hold_asked;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic put_reg(input logic idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[15:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_BLEND)
            weight_q = value & 16'hFFFF;
        else
            scale_q = value & 16'hFFFF;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_tilts.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic offer_sample(input logic signed [15:0] ax, ay, az, gx, gy, gz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        accel_x <= ax; accel_y <= ay; accel_z <= az;
        gyro_x <= gx; gyro_y <= gy; gyro_z <= gz;
        do @(posedge clk); while (in_stall);
    endtask

    function automatic logic signed [15:0] pick_field(input int lim);
        if ($urandom_range(1) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(2 * lim)) - lim);
    endfunction

    task automatic offer_random;
        logic signed [15:0] ax, ay, az;
        ax = pick_field(18000);
        ay = pick_field(18000);
        az = ($urandom_range(9) == 0) ? 16'sd0 : pick_field(18000);
        offer_sample(ax, ay, az, pick_field(2000), pick_field(2000), pick_field(2000));
    endtask

    sample_row_t rows[$];

    function automatic sample_row_t row(input bit set_cfg, input int w, input int s,
                                        input int ax, ay, az, gx, gy, gz);
        sample_row_t r;
        r.set_cfg = set_cfg; r.weight = w; r.scale = s;
        r.ax = 16'(ax); r.ay = 16'(ay); r.az = 16'(az);
        r.gx = 16'(gx); r.gy = 16'(gy); r.gz = 16'(gz);
        r.known = 0;
        r.tilt = '0;
        return r;
    endfunction

    initial
    begin
        sample_row_t r;
        int          phase_pct [0:3][0:1];
        int          weights [0:7];
        int          scales [0:7];
        failures = 0;
        idle_cycles = 0;
        hold_asked = 0; hold_served = 0; hold_left = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        roll_est = 0; pitch_est = 0;
        weight_q = 1311; scale_q = 2750;
        rst_n = 1'b0;
        cfg_write = 1'b0; cfg_index = REG_BLEND; cfg_data = '0;
        in_valid = 1'b0;
        accel_x = '0; accel_y = '0; accel_z = '0;
        gyro_x = '0; gyro_y = '0; gyro_z = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero sample straight after reset keeps both angles at zero
        r = row(0, 0, 0, 0, 0, 0, 0, 0, 0);
        r.known = 1;
        rows.push_back(r);
        rows.push_back(row(0, 0, 0, 32767, 0, 0, 0, 0, 0));
        rows.push_back(row(0, 0, 0, -32768, 0, 0, 0, 0, 0));
        rows.push_back(row(0, 0, 0, 16384, 0, 16384, 0, 0, 0));
        rows.push_back(row(0, 0, 0, 0, 100, 0, 0, 0, 0));
        rows.push_back(row(0, 0, 0, 0, -100, 0, 0, 0, 0));
        rows.push_back(row(0, 0, 0, 5000, 0, 0, 0, 0, 0));
        rows.push_back(row(0, 0, 0, 0, 5000, -16384, 0, 0, 0));
        rows.push_back(row(0, 0, 0, 0, 32767, -32768, 0, 0, 0));
        rows.push_back(row(0, 0, 0, 0, 0, 16384, 32767, 32767, 32767));
        rows.push_back(row(0, 0, 0, 0, 0, 16384, -32768, -32768, -32768));
        // heavy accel weight drives pitch to a right angle
        rows.push_back(row(1, 65535, 2750, 0, 32767, 0, 0, 0, 0));
        rows.push_back(row(0, 0, 0, 0, 32767, 0, 0, 0, 0));
        rows.push_back(row(0, 0, 0, 0, 32767, 0, 1000, 1000, -1000));
        // pure gyro integration at full step runs the angles into saturation
        rows.push_back(row(1, 0, 65535, 0, 0, 16384, 32767, 32767, 32767));
        repeat (4) rows.push_back(row(0, 0, 0, 0, 0, 16384, 32767, 32767, 32767));
        rows.push_back(row(0, 0, 0, 0, 0, 16384, -32768, -32768, -32768));
        rows.push_back(row(1, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(row(1, 32768, 1, -32768, -32768, -32768, -32768, -32768, -32768));
        rows.push_back(row(0, 0, 0, 32767, 32767, 32767, 32767, 32767, 32767));

        foreach (rows[i])
        begin
            if (rows[i].set_cfg)
            begin
                drain();
                put_reg(REG_BLEND, rows[i].weight);
                put_reg(REG_SCALE, rows[i].scale);
            end
            offer_sample(rows[i].ax, rows[i].ay, rows[i].az,
                         rows[i].gx, rows[i].gy, rows[i].gz);
            if (rows[i].known)
            begin
                in_valid <= 1'b0;
                while (pending_tilts.size() != 0) @(posedge clk);
                if (roll_est != rows[i].tilt.roll || pitch_est != rows[i].tilt.pitch)
                begin
                    $error("roll_angle/pitch_angle expected 0/0 actual %0d/%0d",
                           roll_est, pitch_est);
                    failures++;
                end
            end
        end

        phase_pct = '{'{0, 0}, '{47, 0}, '{0, 47}, '{12, 12}};
        weights = '{1311, 0, 65535, 3000, 655, 20000, 1311, 40000};
        scales  = '{2750, 65535, 0, 100, 8000, 2750, 30000, 1};
        for (int p = 0; p < 8; p++)
        begin
            drain();
            put_reg(REG_BLEND, weights[p]);
            put_reg(REG_SCALE, scales[p]);
            send_idle_pct = phase_pct[p % 4][0];
            recv_stall_pct = phase_pct[p % 4][1];
            for (int n = 0; n < RAND_ITEMS; n++)
            begin
                if (p == 4 && n == 10)
                    hold_asked++;
                offer_random();
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        drain();
        if (failures == 0)
            $display("imu_tilt_complementary_filter_test OK");
        else
            $display("imu_tilt_complementary_filter_test NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
